// ===== hw/rtl/hpc_pkg.sv =====
// Package for the half precision converter: conversion kind codes and
// the special bit patterns for infinity and NaN. No dependencies.
`default_nettype none

package hpc_pkg;

	typedef enum logic [1:0] {
		KIND_S2H = 2'd0,
		KIND_D2H = 2'd1,
		KIND_H2S = 2'd2
	} kind_t;

	localparam logic [15:0] HALF_INF    = 16'h7c00;
	localparam logic [15:0] HALF_NAN    = 16'hffff;
	localparam logic [31:0] SINGLE_INF  = 32'h7f800000;
	localparam logic [31:0] SINGLE_NAN  = 32'hffffffff;
	localparam logic [9:0]  FRAC_MASK   = 10'h3ff;
	localparam logic [10:0] HIDDEN_BIT  = 11'h400;

endpackage

`default_nettype wire

// ===== hw/rtl/hpc_req_if.sv =====
// Request channel of the half precision converter: valid/ready plus the
// conversion kind and the source bit pattern. Depends on nothing.
`default_nettype none

interface hpc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [63:0] operand_bits;

	modport source (output valid, output kind, output operand_bits, input ready);
	modport sink (input valid, input kind, input operand_bits, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hpc_rsp_if.sv =====
// Response channel of the half precision converter: valid/ready plus the
// converted bit pattern and the out of range flag. Depends on nothing.
`default_nettype none

interface hpc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;
	logic        out_of_range;

	modport source (output valid, output result_bits, output out_of_range, input ready);
	modport sink (input valid, input result_bits, input out_of_range, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/half_precision_converter.sv =====
// Half precision converter top level: single/double to half and half to single.
// Uses hpc_pkg, hpc_req_if and hpc_rsp_if.
//
// Usage:
//   req carries one item per valid/ready handshake: kind (0 single to half,
//   1 double to half, 2 half to single) and the right aligned source pattern.
//   rsp returns one item per request: result_bits (half in bits 15..0, or a
//   full single) and out_of_range, set with a zero result when the rounded
//   magnitude is above the half range.
//   Each request passes through the input register, loaded on acceptance,
//   and then the result register, which captures the conversion logic
//   (field unpack, round, leading one search for half subnormals).
//   Throughput is one item per cycle while rsp.ready is high; req.ready stays
//   high while rsp.ready is high or a pipeline slot is empty.
//   When rsp stalls, the result register holds its item and the input
//   register fills; req.ready then drops until rsp.ready returns.
//   Reset clears both valid bits; no item is in flight afterwards.
`default_nettype none

module half_precision_converter (
	input  wire logic clk,
	input  wire logic arst_n,
	hpc_req_if.sink   req,
	hpc_rsp_if.source rsp
);
	import hpc_pkg::*;

	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [63:0] operand_s1;
	logic        valid_s2;
	logic [31:0] result_s2;
	logic        oor_s2;

	logic        adv_s2;
	logic        adv_s1;
	logic [31:0] result_d;
	logic        oor_d;

	function automatic logic [16:0] narrow(input logic sign, input logic signed [12:0] e_in,
		input logic [9:0] top, input logic rbit);
		logic [11:0]        m;
		logic signed [12:0] e;
		logic signed [12:0] sh;
		logic [10:0]        ms;
		logic [4:0]         be;
		m  = {1'b0, HIDDEN_BIT | {1'b0, top}} + {11'd0, rbit};
		e  = e_in;
		ms = '0;
		be = '0;
		sh = '0;
		if (m[11]) begin
			m = m >> 1;
			e = e + 13'sd1;
		end
		if (e < -13'sd14) begin
			sh = -13'sd14 - e;
			if (sh <= 13'sd10) begin
				ms = m[10:0] >> sh[3:0];
			end
			narrow = {1'b0, sign, 5'd0, ms[9:0]};
		end else if (e > 13'sd15) begin
			narrow = {1'b1, 16'd0};
		end else begin
			be     = 5'(e + 13'sd15);
			narrow = {1'b0, sign, be, m[9:0] & FRAC_MASK};
		end
	endfunction

	function automatic logic [31:0] widen(input logic [15:0] h);
		logic       sign;
		logic [4:0] ex;
		logic [9:0] fr;
		logic [3:0] p;
		logic [3:0] k;
		logic [9:0] frn;
		logic [7:0] be;
		sign = h[15];
		ex   = h[14:10];
		fr   = h[9:0];
		p    = '0;
		for (int i = 0; i < 10; i++) begin
			if (fr[i]) begin
				p = 4'(i);
			end
		end
		k   = 4'd10 - p;
		frn = 10'(fr << k);
		be  = 8'(p) + 8'd103;
		if (ex == 5'h1f) begin
			widen = (fr == '0) ? (SINGLE_INF | {sign, 31'd0}) : SINGLE_NAN;
		end else if (ex == '0 && fr == '0) begin
			widen = {sign, 31'd0};
		end else if (ex == '0) begin
			widen = {sign, be, frn, 13'd0};
		end else begin
			widen = {sign, {3'd0, ex} + 8'd112, fr, 13'd0};
		end
	endfunction

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_comb begin
		logic [16:0] nr;
		logic [7:0]  sex;
		logic [10:0] dex;
		nr       = '0;
		sex      = operand_s1[30:23];
		dex      = operand_s1[62:52];
		result_d = '0;
		oor_d    = 1'b0;
		case (kind_t'(kind_s1))
			KIND_S2H: begin
				nr = narrow(operand_s1[31], $signed({5'd0, sex}) - 13'sd127,
					operand_s1[22:13], operand_s1[12]);
				if (sex == 8'hff) begin
					result_d = {16'd0, (operand_s1[22:0] == '0) ?
						(HALF_INF | {operand_s1[31], 15'd0}) : HALF_NAN};
				end else if (sex == '0) begin
					result_d = {16'd0, operand_s1[31], 15'd0};
				end else begin
					result_d = {16'd0, nr[15:0]};
					oor_d    = nr[16];
				end
			end
			KIND_D2H: begin
				nr = narrow(operand_s1[63], $signed({2'd0, dex}) - 13'sd1023,
					operand_s1[51:42], operand_s1[41]);
				if (dex == 11'h7ff) begin
					result_d = {16'd0, (operand_s1[51:0] == '0) ?
						(HALF_INF | {operand_s1[63], 15'd0}) : HALF_NAN};
				end else if (dex == '0) begin
					result_d = {16'd0, operand_s1[63], 15'd0};
				end else begin
					result_d = {16'd0, nr[15:0]};
					oor_d    = nr[16];
				end
			end
			KIND_H2S: begin
				result_d = widen(operand_s1[15:0]);
			end
			default: begin
				result_d = '0;
				oor_d    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			kind_s1    <= req.kind;
			operand_s1 <= req.operand_bits;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_d;
			oor_s2    <= oor_d;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.result_bits  = result_s2;
	assign rsp.out_of_range = oor_s2;

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && oor_s2 |-> result_s2 == '0)
		else $error("out of range item carries a nonzero result");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted item missing from input register");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(operand_s1) && $stable(kind_s1))
		else $error("input register lost a stalled item");

	a_narrow_half: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && kind_s1 != KIND_H2S |=> result_s2[31:16] == '0)
		else $error("narrowed result has upper bits set");

endmodule

`default_nettype wire

// ===== dv/tb_half_precision_converter.sv =====
// Testbench for half_precision_converter: directed and random conversions checked
// against a built-in predictor, with random idling on both channels.
// Depends on hpc_pkg, hpc_req_if, hpc_rsp_if and the converter RTL.
`timescale 1ns / 100ps

module tb_half_precision_converter;
	import hpc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_ITEMS   = 1620;

	typedef struct packed {
		logic [31:0] result_bits;
		logic        out_of_range;
	} conv_result_t;

	logic clk = 1'b0;
	logic arst_n;

	hpc_req_if req_ch ();
	hpc_rsp_if rsp_ch ();

	half_precision_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	conv_result_t pending_results[$];
	conv_result_t got_result;
	conv_result_t want_result;
	int           fail_count  = 0;
	int           idle_cycles = 0;
	bit           burst_mode  = 1'b0;

	always #5ns clk = ~clk;

	function automatic conv_result_t predict_conversion(logic [1:0] k, logic [63:0] op);
		conv_result_t r;
		logic [15:0]  sgn;
		int unsigned  ex;
		int           e;
		int           sh;
		logic [9:0]   top;
		logic         rbit;
		logic         exp_full;
		logic         frac_zero;
		logic [11:0]  m;
		logic [10:0]  hf;
		r = '0;
		sgn = '0;
		ex = 0;
		e = 0;
		top = '0;
		rbit = 1'b0;
		exp_full = 1'b0;
		frac_zero = 1'b0;
		case (k)
			KIND_H2S: begin
				hf = {1'b0, op[9:0]};
				if (op[14:10] == 5'h1f) begin
					r.result_bits = (op[9:0] == '0) ? ({op[15], 31'b0} | SINGLE_INF) : SINGLE_NAN;
				end else if (op[14:10] == '0 && op[9:0] == '0) begin
					r.result_bits = {op[15], 31'b0};
				end else begin
					if (op[14:10] == '0) begin
						e = -14;
						while (!hf[10]) begin
							hf = hf << 1;
							e--;
						end
					end else begin
						e = int'(op[14:10]) - 15;
					end
					r.result_bits = {op[15], 8'(e + 127), hf[9:0], 13'b0};
				end
			end
			KIND_S2H, KIND_D2H: begin
				if (k == KIND_S2H) begin
					sgn = {op[31], 15'b0};
					ex = op[30:23];
					e = int'(ex) - 127;
					exp_full = &op[30:23];
					frac_zero = (op[22:0] == '0);
					top = op[22:13];
					rbit = op[12];
				end else begin
					sgn = {op[63], 15'b0};
					ex = op[62:52];
					e = int'(ex) - 1023;
					exp_full = &op[62:52];
					frac_zero = (op[51:0] == '0);
					top = op[51:42];
					rbit = op[41];
				end
				if (exp_full) begin
					r.result_bits = {16'b0, frac_zero ? (sgn | HALF_INF) : HALF_NAN};
				end else if (ex == 0) begin
					r.result_bits = {16'b0, sgn};
				end else begin
					m = {2'b01, top} + 12'(rbit);
					if (m[11]) begin
						m = m >> 1;
						e++;
					end
					if (e < -14) begin
						sh = -14 - e;
						m = (sh <= 10) ? (m >> sh) : '0;
						r.result_bits = {16'b0, sgn | {5'b0, m[10:0]}};
					end else if (e > 15) begin
						r.out_of_range = 1'b1;
					end else begin
						r.result_bits = {16'b0, sgn[15], 5'(e + 15), m[9:0]};
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] random_operand(logic [1:0] k);
		logic [63:0] v;
		int unsigned sel;
		v = {$urandom, $urandom};
		sel = $urandom_range(0, 9);
		case (k)
			KIND_S2H: begin
				if (sel < 6 || sel == 8) begin
					v[30:23] = 8'(101 + $urandom_range(0, 43));
				end else if (sel == 6) begin
					v[30:23] = 8'hff;
				end else if (sel == 7) begin
					v[30:23] = '0;
				end
				if (sel == 8) begin
					v[22:12] = '1;
				end
				if (sel == 6 && $urandom_range(0, 1) == 0) begin
					v[22:0] = '0;
				end
			end
			KIND_D2H: begin
				if (sel < 6 || sel == 8) begin
					v[62:52] = 11'(997 + $urandom_range(0, 43));
				end else if (sel == 6) begin
					v[62:52] = 11'h7ff;
				end else if (sel == 7) begin
					v[62:52] = '0;
				end
				if (sel == 8) begin
					v[51:41] = '1;
				end
				if (sel == 6 && $urandom_range(0, 1) == 0) begin
					v[51:0] = '0;
				end
			end
			default: begin
				if (sel < 2) begin
					v[14:10] = '0;
				end else if (sel == 2) begin
					v[14:10] = 5'h1f;
					if ($urandom_range(0, 1) == 0) begin
						v[9:0] = '0;
					end
				end
			end
		endcase
		return v;
	endfunction

	task automatic send_item(logic [1:0] k, logic [63:0] op);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= k;
		req_ch.operand_bits <= op;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_single_to_half();
		logic [63:0] pats [10];
		pats = '{64'h0000_0000_8000_0000, 64'h0000_0000_0000_0001, 64'h0000_0000_ff80_0000,
			64'h0000_0000_7f80_0001, 64'hffff_ffff_477f_e000, 64'h0000_0000_477f_f000,
			64'h0000_0000_3fff_f000, 64'h0000_0000_3880_0000, 64'h0000_0000_b800_0000,
			64'h0000_0000_3300_0000};
		foreach (pats[i]) send_item(KIND_S2H, pats[i]);
	endtask

	task automatic test_double_to_half();
		logic [63:0] pats [8];
		pats = '{64'h0000_0000_0000_0000, 64'h000f_ffff_ffff_ffff, 64'h7ff0_0000_0000_0000,
			64'hfff8_0000_0000_0000, 64'h40ef_fe00_0000_0000, 64'h3e70_0000_0000_0000,
			64'hbff0_0000_0000_0000, 64'h3fff_fe00_0000_0000};
		foreach (pats[i]) send_item(KIND_D2H, pats[i]);
	endtask

	task automatic test_half_to_single();
		logic [63:0] pats [8];
		pats = '{64'h8000, 64'h0001, 64'h03ff, 64'h7bff, 64'hfc00, 64'h7c01,
			64'hffff_ffff_ffff_3c00, 64'h0400};
		foreach (pats[i]) send_item(KIND_H2S, pats[i]);
	endtask

	task automatic test_random_mix();
		logic [1:0] k;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				burst_mode = ($urandom_range(0, 3) == 0);
			end
			if (i % 400 == 399) begin
				wait_drained();
			end
			k = 2'($urandom_range(0, 2));
			send_item(k, random_operand(k));
		end
		burst_mode = 1'b0;
	endtask

	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = burst_mode ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_result = '{rsp_ch.result_bits, rsp_ch.out_of_range};
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("unexpected item: result_bits %h out_of_range %b",
							got_result.result_bits, got_result.out_of_range);
					end
				end else begin
					want_result = pending_results.pop_front();
					if (got_result.result_bits !== want_result.result_bits ||
							got_result.out_of_range !== want_result.out_of_range) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("mismatch: result_bits %h/%h out_of_range %b/%b (exp/act)",
								want_result.result_bits, got_result.result_bits,
								want_result.out_of_range, got_result.out_of_range);
						end
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				pending_results.push_back(predict_conversion(req_ch.kind, req_ch.operand_bits));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.kind         <= KIND_S2H;
		req_ch.operand_bits <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_to_half();
		test_double_to_half();
		test_half_to_single();
		test_random_mix();
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
